// ----- rtl/text_to_int_any_base_defines.svh -----
// assertion helpers used by the rtl in text_to_int_any_base.sv
`ifndef TEXT_TO_INT_ANY_BASE_DEFINES_SVH
`define TEXT_TO_INT_ANY_BASE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TTI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tti_pkg.sv -----
`timescale 1ns / 1ps

package tti_pkg;

    localparam int C_MAX_SYMBOLS = 32;
    localparam int C_LEN_W       = 6;
    localparam int C_BYTE_W      = 8;
    localparam int C_VALUE_W     = 32;
    localparam int C_CFG_DATA_W  = 64;
    localparam int C_CFG_IDX_W   = 3;
    localparam int C_SYMS_PER_REG = 8;

    // register indexes
    localparam logic [C_CFG_IDX_W-1:0] C_REG_LENGTH = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_SYM0   = 3'd1;

    // byte codes
    localparam logic [C_BYTE_W-1:0] C_TAB   = 8'd9;
    localparam logic [C_BYTE_W-1:0] C_CR    = 8'd13;
    localparam logic [C_BYTE_W-1:0] C_SPACE = 8'd32;
    localparam logic [C_BYTE_W-1:0] C_DEL   = 8'd127;
    localparam logic [C_BYTE_W-1:0] C_PLUS  = 8'h2B;
    localparam logic [C_BYTE_W-1:0] C_MINUS = 8'h2D;

    localparam logic [C_LEN_W-1:0] C_MIN_LEN = 6'd2;

    typedef enum logic [3:0] {
        PH_BLANK = 4'b0001,
        PH_SIGN  = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

endpackage

// ----- rtl/text_to_int_any_base.sv -----
`timescale 1ns / 1ps
// channel | direction | handshake                      | payload
// in      | to block  | i_in_valid / o_in_stall        | i_text_byte, i_starts_text
// out     | from block| o_out_valid / i_out_stall      | o_parsed_value, o_alphabet_valid
// cfg     | to block  | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// one byte a cycle unless a register write or a held result stalls it: input
// register, then parse step (compare bank and a 32x6 multiply-add) into the state
// and the result register, which drives the output
// alphabet check is registered, so the parse step waits after each register write
// synchronous active-low reset clears parse state, configuration registers and both valids
// a held result stalls the parse step only when the byte would emit a result

`include "text_to_int_any_base_defines.svh"

module text_to_int_any_base
    import tti_pkg::*;
#(
    parameter int MAX_SYMBOLS = C_MAX_SYMBOLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input beats
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [C_BYTE_W-1:0]           i_text_byte,
    input  logic                          i_starts_text,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [C_VALUE_W-1:0]   o_parsed_value,
    output logic                          o_alphabet_valid,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [C_CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [C_CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int DIGIT_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    // configuration
    logic [C_LEN_W-1:0]  r_alphabet_length;
    logic [C_BYTE_W-1:0] r_symbols [MAX_SYMBOLS];
    logic                r_alph_valid;
    logic                n_alph_valid;
    logic                r_cfg_hold;

    // input register
    logic                r_in_valid;
    logic [C_BYTE_W-1:0] r_in_byte;
    logic                r_in_start;

    // parse state
    t_phase              r_phase;
    t_phase              n_phase;
    logic [C_VALUE_W-1:0] r_acc;
    logic [C_VALUE_W-1:0] n_acc;
    logic                r_neg;
    logic                n_neg;

    // result register
    logic                r_out_valid;
    logic [C_VALUE_W-1:0] r_out_value;
    logic                r_out_alph_valid;

    logic                      w_in_accept;
    logic                      w_fire;
    logic                      w_emit;
    logic                      w_blank;
    logic                      w_sign;
    logic                      w_digit_hit;
    logic [MAX_SYMBOLS-1:0]    w_in_use;
    logic [MAX_SYMBOLS-1:0]    w_match;
    logic [DIGIT_W-1:0]        w_digit;
    t_phase                    w_cur_phase;
    logic [C_VALUE_W-1:0]      w_cur_acc;
    logic                      w_cur_neg;
    logic [C_VALUE_W-1:0]      w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet_length <= '0;
            for (int k = 0; k < MAX_SYMBOLS; k++) begin
                r_symbols[k] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == C_REG_LENGTH) begin
                r_alphabet_length <= i_cfg_data[C_LEN_W-1:0];
            end
            for (int k = 0; k < MAX_SYMBOLS; k++) begin
                if (i_cfg_index == C_REG_SYM0 + C_CFG_IDX_W'(k >> 3)) begin
                    r_symbols[k] <= i_cfg_data[C_BYTE_W*(k & (C_SYMS_PER_REG-1)) +: C_BYTE_W];
                end
            end
        end
    end

    // alphabet check: flat compare bank over the symbols in use
    always_comb begin
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            w_in_use[k] = C_LEN_W'(k) < r_alphabet_length;
        end
        n_alph_valid = (r_alphabet_length >= C_MIN_LEN)
                    && (r_alphabet_length <= C_LEN_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (w_in_use[i]) begin
                if (r_symbols[i] <= C_SPACE || r_symbols[i] == C_DEL
                        || r_symbols[i] == C_PLUS || r_symbols[i] == C_MINUS) begin
                    n_alph_valid = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if (w_in_use[j] && r_symbols[j] == r_symbols[i]) begin
                        n_alph_valid = 1'b0;
                    end
                end
            end
        end
    end

    // hold the parse step while the registered check catches up with a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alph_valid <= 1'b0;
            r_cfg_hold   <= 1'b0;
        end else begin
            r_alph_valid <= n_alph_valid;
            r_cfg_hold   <= i_cfg_valid && o_cfg_ready;
        end
    end

    // handshake
    assign w_fire      = r_in_valid && !r_cfg_hold && !(w_emit && r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && !w_fire;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte  <= i_text_byte;
            r_in_start <= i_starts_text;
        end
    end

    // digit lookup
    always_comb begin
        w_digit = '0;
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            w_match[k] = r_alph_valid && w_in_use[k] && (r_symbols[k] == r_in_byte);
            if (w_match[k]) begin
                w_digit = w_digit | DIGIT_W'(k);
            end
        end
        w_digit_hit = |w_match;
    end

    assign w_blank = ((r_in_byte >= C_TAB) && (r_in_byte <= C_CR)) || (r_in_byte == C_SPACE);
    assign w_sign  = (r_in_byte == C_PLUS) || (r_in_byte == C_MINUS);

    // parse step
    always_comb begin
        w_cur_phase = r_in_start ? PH_BLANK : r_phase;
        w_cur_acc   = r_in_start ? '0 : r_acc;
        w_cur_neg   = r_in_start ? 1'b0 : r_neg;
        n_phase     = w_cur_phase;
        n_acc       = w_cur_acc;
        n_neg       = w_cur_neg;
        w_emit      = 1'b0;
        priority if (w_cur_phase == PH_DONE) begin
            n_phase = PH_DONE;
        end else if (w_cur_phase == PH_BLANK && w_blank) begin
            n_phase = PH_BLANK;
        end else if ((w_cur_phase == PH_BLANK || w_cur_phase == PH_SIGN) && w_sign) begin
            n_phase = PH_SIGN;
            n_neg   = w_cur_neg ^ (r_in_byte == C_MINUS);
        end else if (w_digit_hit) begin
            n_phase = PH_DIGIT;
            n_acc   = C_VALUE_W'(w_cur_acc * C_VALUE_W'(r_alphabet_length))
                    + C_VALUE_W'(w_digit);
        end else begin
            n_phase = PH_DONE;
            w_emit  = 1'b1;
        end
    end

    assign w_result = !r_alph_valid ? '0 : (w_cur_neg ? ('0 - w_cur_acc) : w_cur_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BLANK;
            r_acc   <= '0;
            r_neg   <= 1'b0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out_value      <= w_result;
            r_out_alph_valid <= r_alph_valid;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_parsed_value   = r_out_value;
    assign o_alphabet_valid = r_out_alph_valid;

    `TTI_ASSERT_NOW(a_invalid_gives_zero, r_out_valid && !r_out_alph_valid, r_out_value == '0, "invalid alphabet result not zero")
    `TTI_ASSERT_NOW(a_digit_unique, r_alph_valid && r_in_valid, $onehot0(w_match), "byte matched more than one digit")
    `TTI_ASSERT_NEXT(a_digit_phase, w_fire && w_emit == 1'b0 && w_digit_hit && w_cur_phase != PH_DONE && !w_blank && !w_sign, r_phase == PH_DIGIT, "digit did not enter digit phase")
    `TTI_ASSERT_NEXT(a_done_silent, w_fire && w_cur_phase == PH_DONE, r_out_valid == $past(r_out_valid && i_out_stall), "result emitted after end of text")

endmodule
